// File: rtl/bac_pkg.sv
package bac_pkg;

	// field types
	typedef logic [11:0] sample_t;
	typedef logic [11:0] supply_t;
	typedef logic [12:0] mv_t;
	typedef logic [9:0]  charge_t;
	typedef logic [30:0] recip_t;

	// supply register value after reset
	localparam supply_t SUPPLY_RST = 12'd3300;

	// x / 11 == (x * 47663) >> 19 for every x below 2^15
	localparam logic [15:0] REC_MUL   = 16'd47663;
	localparam int          REC_SHIFT = 19;

	// battery voltage is always a multiple of 32 mV; q = mv / 32
	// q at or below Q_FLOOR is at or below 3500 mV, q at or above Q_CEIL is at or above 4200 mV
	localparam logic [11:0] Q_FLOOR = 12'd109;
	localparam logic [11:0] Q_BASE  = 12'd110;
	localparam logic [11:0] Q_CEIL  = 12'd132;

	localparam logic [16:0] MV_SAT      = 17'd8191;
	localparam charge_t     CHARGE_FULL = 10'd1000;
	localparam charge_t     CHARGE_NONE = 10'd0;

	// interpolated lipo curve, sampled at every reachable voltage from 3520 mV to 4192 mV
	// in 32 mV steps; index 0 is 3520 mV
	function automatic charge_t charge_lut(input logic [4:0] idx);
		charge_t c;
		case (idx)
			5'd0:    c = 10'd7;
			5'd1:    c = 10'd18;
			5'd2:    c = 10'd29;
			5'd3:    c = 10'd40;
			5'd4:    c = 10'd52;
			5'd5:    c = 10'd63;
			5'd6:    c = 10'd74;
			5'd7:    c = 10'd85;
			5'd8:    c = 10'd96;
			5'd9:    c = 10'd145;
			5'd10:   c = 10'd225;
			5'd11:   c = 10'd303;
			5'd12:   c = 10'd343;
			5'd13:   c = 10'd383;
			5'd14:   c = 10'd460;
			5'd15:   c = 10'd550;
			5'd16:   c = 10'd620;
			5'd17:   c = 10'd674;
			5'd18:   c = 10'd754;
			5'd19:   c = 10'd845;
			5'd20:   c = 10'd920;
			5'd21:   c = 10'd984;
			default: c = CHARGE_NONE;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/bac_mv_scale.sv
module bac_mv_scale
	import bac_pkg::*;
#(
	parameter int ADC_BITS = 12
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t in_sample,
	input  supply_t supply,
	output logic    out_valid,
	input  logic    out_ready,
	output recip_t  out_recip
);

	logic [23:0] prod_s1;
	logic        vld_s1;
	recip_t      recip_s2;
	logic        vld_s2;

	logic        ready_s1;
	logic        ready_s2;
	logic [23:0] shifted;
	logic [15:0] adc_mv;
	logic [14:0] half_mv;
	recip_t      recip_d;

	// stage advance when empty or when the next stage takes its contents
	assign ready_s2 = !vld_s2 || out_ready;
	assign ready_s1 = !vld_s1 || ready_s2;
	assign in_ready = ready_s1;

	// stage 1: sample times supply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			prod_s1 <= {12'd0, in_sample} * {12'd0, supply};
		end
	end

	// scale to adc millivolts, then divide by 22 as halve and multiply by 1/11
	assign shifted = prod_s1 >> ADC_BITS;
	assign adc_mv  = shifted[15:0];
	assign half_mv = adc_mv[15:1];
	assign recip_d = {16'd0, half_mv} * {15'd0, REC_MUL};

	// stage 2: reciprocal product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ready_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			recip_s2 <= recip_d;
		end
	end

	assign out_valid = vld_s2;
	assign out_recip = recip_s2;

endmodule

// File: rtl/bac_charge_map.sv
module bac_charge_map
	import bac_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  recip_t  in_recip,
	output logic    out_valid,
	input  logic    out_ready,
	output mv_t     out_mv,
	output charge_t out_charge
);

	logic        vld_s3;
	mv_t         mv_s3;
	charge_t     charge_s3;

	logic        ready_s3;
	logic [11:0] quot;
	logic [16:0] mv_full;
	logic [11:0] idx_full;
	mv_t         mv_d;
	charge_t     charge_d;

	assign ready_s3 = !vld_s3 || out_ready;
	assign in_ready = ready_s3;

	// quotient by 22, times 32 gives battery millivolts
	assign quot    = in_recip[30:REC_SHIFT];
	assign mv_full = {quot, 5'd0};
	assign mv_d    = (mv_full > MV_SAT) ? MV_SAT[12:0] : mv_full[12:0];

	// clamp at both ends of the curve, table in between
	assign idx_full = quot - Q_BASE;

	always_comb begin
		if (quot >= Q_CEIL) begin
			charge_d = CHARGE_FULL;
		end else if (quot <= Q_FLOOR) begin
			charge_d = CHARGE_NONE;
		end else begin
			charge_d = charge_lut(idx_full[4:0]);
		end
	end

	// stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ready_s3) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			mv_s3     <= mv_d;
			charge_s3 <= charge_d;
		end
	end

	assign out_valid  = vld_s3;
	assign out_mv     = mv_s3;
	assign out_charge = charge_s3;

endmodule

// File: rtl/battery_adc_to_charge_percent.sv
// Converts one ADC sample of a single-cell lipo battery divider into battery millivolts
// (floor(floor(sample * supply_mv / 2^ADC_BITS) / 22) * 32, saturated at 8191) and a state of
// charge in tenths of a percent from a piecewise linear curve, 1000 at or above 4200 mV and 0 at
// or below 3500 mV. The block is a three-stage pipeline: one sample can be taken every clock
// unless a stalled output has filled every stage, and each result passes the stage 1, 2 and 3
// registers in turn before it is valid at the output; the depth is set by the two multipliers,
// one in each of the first two stages, with the curve lookup in the third. A stalled output
// holds the pipeline and new samples are still taken until every stage is full.
// supply_mv resets to 3300 and must be written only while no sample is in flight.
module battery_adc_to_charge_percent
	import bac_pkg::*;
#(
	parameter int ADC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [11:0] adc_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [12:0] battery_mv, [22:13] charge_tenths
	input  logic        cfg_wr_en,
	input  logic [11:0] cfg_wr_data    // supply_mv
);

	supply_t supply_q;
	logic    mid_valid;
	logic    mid_ready;
	recip_t  mid_recip;
	mv_t     battery_mv;
	charge_t charge_tenths;

	// supply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= SUPPLY_RST;
		end else if (cfg_wr_en) begin
			supply_q <= cfg_wr_data;
		end
	end

	// voltage scaling, stages 1 and 2
	bac_mv_scale #(
		.ADC_BITS(ADC_BITS)
	) u_mv_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample (s_axis_tdata[11:0]),
		.supply    (supply_q),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_recip (mid_recip)
	);

	// curve lookup and output register, stage 3
	bac_charge_map u_charge_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (mid_valid),
		.in_ready   (mid_ready),
		.in_recip   (mid_recip),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_mv     (battery_mv),
		.out_charge (charge_tenths)
	);

	assign m_axis_tdata = {1'b0, charge_tenths, battery_mv};

endmodule

// File: rtl/bac_chk.sv
module bac_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// a waiting sample holds until its transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
		else $error("sample changed while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// charge never exceeds full
	a_charge_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[22:13] <= 10'd1000)
		else $error("charge above 1000");

	// voltage is a multiple of 32 unless saturated
	a_mv_grid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[4:0] == 5'd0) || (m_axis_tdata[12:0] == 13'd8191))
		else $error("voltage off the 32 mV grid");

	// charge agrees with the voltage at both ends of the curve
	a_curve_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			((m_axis_tdata[12:0] >= 13'd4200) ? (m_axis_tdata[22:13] == 10'd1000) :
			 (m_axis_tdata[12:0] <= 13'd3500) ? (m_axis_tdata[22:13] == 10'd0) :
			 (m_axis_tdata[22:13] != 10'd0) && (m_axis_tdata[22:13] != 10'd1000)))
		else $error("charge does not match voltage at curve ends");

endmodule

bind battery_adc_to_charge_percent bac_chk u_bac_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_battery_adc_to_charge_percent.sv
module tb_battery_adc_to_charge_percent;
	import bac_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	// one converted reading as it leaves the block
	typedef struct {
		mv_t     mv;
		charge_t charge;
	} reading_t;

	// expected readings in arrival order, with a private copy of the supply register
	class charge_scoreboard;
		supply_t  supply_mv;
		reading_t expected_readings[$];
		int       errors;
		int       checked;
		int       mid_curve;
		int       full_charge;
		int       empty_charge;

		function new();
			supply_mv = SUPPLY_RST;
			errors = 0;
			checked = 0;
			mid_curve = 0;
			full_charge = 0;
			empty_charge = 0;
		endfunction

		// lipo discharge curve knots, top of charge first
		function int curve_point(int i);
			case (i)
				0:       return 4200;
				1:       return 4150;
				2:       return 4110;
				3:       return 4080;
				4:       return 4020;
				5:       return 3980;
				6:       return 3950;
				7:       return 3870;
				8:       return 3830;
				9:       return 3790;
				default: return 3500;
			endcase
		endfunction

		// piecewise linear lookup, upper segment wins on a knot
		function int charge_of(int mv);
			int hi;
			int lo;
			if (mv >= curve_point(0))
				return 1000;
			if (mv <= curve_point(10))
				return 0;
			for (int seg = 0; seg < 10; seg++) begin
				hi = curve_point(seg);
				lo = curve_point(seg + 1);
				if (mv <= hi && mv >= lo)
					return 1000 - seg * 100 - ((hi - mv) * 100) / (hi - lo);
			end
			return 0;
		endfunction

		function reading_t predict_reading(sample_t smp);
			reading_t    r;
			int unsigned adc_mv;
			int unsigned batt_mv;
			adc_mv  = (int'(smp) * int'(supply_mv)) >> 12;
			batt_mv = (adc_mv / 22) * 32;
			r.mv     = (batt_mv > 8191) ? mv_t'(8191) : mv_t'(batt_mv);
			r.charge = charge_t'(charge_of(int'(batt_mv)));
			return r;
		endfunction

		function void note_sample(sample_t smp);
			expected_readings.push_back(predict_reading(smp));
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_reading(mv_t mv, charge_t charge);
			reading_t want;
			if (expected_readings.size() == 0) begin
				report($sformatf("result with nothing pending, mv=%0d charge=%0d", mv, charge));
				return;
			end
			want = expected_readings.pop_front();
			checked++;
			if (mv !== want.mv)
				report($sformatf("reading %0d battery_mv got %0d want %0d",
					checked, mv, want.mv));
			if (charge !== want.charge)
				report($sformatf("reading %0d charge_tenths got %0d want %0d",
					checked, charge, want.charge));
			if (want.charge == 0)
				empty_charge++;
			else if (want.charge == 1000)
				full_charge++;
			else
				mid_curve++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_wr_en = 1'b0;
	logic [11:0] cfg_wr_data = '0;

	charge_scoreboard board;
	int samples_sent = 0;
	int supply_writes = 0;
	int quiet_cycles = 0;
	int unsigned rx_cycle = 0;

	battery_adc_to_charge_percent uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// receiver backpressure, switching among four styles in turn
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case (rx_cycle[9:8])
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ((rx_cycle % 7) < 2);
		endcase
	end

	// result side checking
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_reading(m_axis_tdata[12:0], m_axis_tdata[22:13]);
	end

	// stall watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", quiet_cycles);
			$display("tb_battery_adc_to_charge_percent failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one sample transfer, valid stays high on return
	task send_sample(sample_t smp);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, smp};
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_sample(smp);
		samples_sent++;
	endtask

	task pause_sender(int cycles);
		s_axis_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task drain_results();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// supply written only with the pipeline empty
	task write_supply(supply_t value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.supply_mv = value;
		supply_writes++;
	endtask

	// sample that lands on battery_mv = 32 * step under the current supply, -1 if none
	function int sample_for_step(int step, bit jitter);
		int unsigned supply;
		int unsigned base;
		int unsigned span;
		supply = board.supply_mv;
		if (supply == 0)
			return -1;
		base = (22 * step * 4096 + supply - 1) / supply;
		if (base > 4095)
			return -1;
		span = (22 * 4096) / supply;
		if (jitter)
			base += $urandom_range(0, span - 1);
		return (base > 4095) ? 4095 : int'(base);
	endfunction

	// mostly aimed at the curve region, the rest spread over the whole range
	function sample_t random_sample();
		int s;
		if ($urandom_range(0, 9) < 7) begin
			s = sample_for_step($urandom_range(107, 134), 1'b1);
			if (s >= 0)
				return sample_t'(s);
		end
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return '1;
			default: return sample_t'($urandom_range(0, 4095));
		endcase
	endfunction

	// bursts of random length with random gaps; optional full drain halfway
	task run_random(int count, bit drain_midway);
		int burst_left;
		int gap;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (drain_midway && i == count / 2)
				drain_results();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 32);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0)
					pause_sender(gap);
			end
			send_sample(random_sample());
			burst_left--;
		end
	endtask

	initial begin
		int s;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: range ends, then every 32 mV step across the curve at reset supply
		send_sample('0);
		send_sample('1);
		for (int step = 109; step <= 132; step++) begin
			s = sample_for_step(step, 1'b0);
			if (s >= 0)
				send_sample(sample_t'(s));
		end

		// random phases over several supply settings, extremes included
		write_supply(12'd3600);
		run_random(250, 1'b0);
		write_supply(12'd1800);
		run_random(150, 1'b0);
		write_supply(12'd4095);
		run_random(200, 1'b0);
		write_supply(12'd0);
		run_random(80, 1'b0);
		repeat (3) begin
			write_supply(supply_t'($urandom_range(1800, 3600)));
			run_random(200, 1'b0);
		end
		write_supply(SUPPLY_RST);
		run_random(300, 1'b1);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d readings never arrived", board.pending()));

		$display("sent %0d samples across %0d supply writes, %0d readings checked",
			samples_sent, supply_writes, board.checked);
		$display("charge at 0: %0d, on the curve: %0d, at full: %0d",
			board.empty_charge, board.mid_curve, board.full_charge);
		if (board.errors == 0)
			$display("tb_battery_adc_to_charge_percent passed");
		else
			$display("tb_battery_adc_to_charge_percent failed");
		$finish;
	end

endmodule
